@@ src/rmof_pkg.sv @@
// rmof_pkg: shared widths, reset values and register codes for the
// range median outlier filter. no dependencies.
`default_nettype none

package rmof_pkg;

   localparam int unsigned RANGE_W        = 16;
   localparam int unsigned INTERVAL_W     = 16;
   localparam int unsigned CSR_IDX_W      = 2;
   localparam int unsigned CSR_DATA_W     = 16;
   localparam int unsigned RING_DEPTH_DEF = 8;

   typedef logic [RANGE_W-1:0]    range_type;
   typedef logic [INTERVAL_W-1:0] interval_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam interval_type INTERVAL_LIMIT_MS = 16'd1000;
   localparam range_type    MAX_RANGE_RESET   = 16'd10000;
   localparam range_type    MAX_DEV_RESET     = 16'd500;

   localparam csr_idx_type CSR_MAX_RANGE = 2'd0;
   localparam csr_idx_type CSR_MAX_DEV   = 2'd1;

endpackage

`default_nettype wire

@@ src/rmof_req_if.sv @@
// rmof_req_if: input sample channel, valid/ready plus range and interval.
// depends on rmof_pkg.
`default_nettype none

interface rmof_req_if;
   logic                     valid;
   logic                     ready;
   rmof_pkg::range_type      range_sample;
   rmof_pkg::interval_type   interval_ms;

   modport source (output valid, output range_sample, output interval_ms, input ready);
   modport sink   (input valid, input range_sample, input interval_ms, output ready);
endinterface

`default_nettype wire

@@ src/rmof_rsp_if.sv @@
// rmof_rsp_if: filtered result channel, valid/ready plus filtered range.
// depends on rmof_pkg.
`default_nettype none

interface rmof_rsp_if;
   logic                  valid;
   logic                  ready;
   rmof_pkg::range_type   filtered_range;

   modport source (output valid, output filtered_range, input ready);
   modport sink   (input valid, input filtered_range, output ready);
endinterface

`default_nettype wire

@@ src/rmof_csr_if.sv @@
// rmof_csr_if: register write channel, valid/ready plus index and data.
// depends on rmof_pkg.
`default_nettype none

interface rmof_csr_if;
   logic                     valid;
   logic                     ready;
   rmof_pkg::csr_idx_type    index;
   rmof_pkg::csr_data_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/range_median_outlier_filter.sv @@
// range_median_outlier_filter: ring of recent samples, rank median by one
// shared comparator, deviation gate. depends on rmof_pkg and the rmof_*_if files.
//
// channel  dir  handshake     payload
// req_if   in   valid/ready   range_sample[15:0], interval_ms[15:0]
// rsp_if   out  valid/ready   filtered_range[15:0]
// csr_if   in   valid/ready   index[1:0], data[15:0]
//
// a passing sample goes through ST_SCAN, where the single comparator
// walks every pair of ring entries, then through ST_DRAIN and ST_DECIDE.
// a rejected sample goes straight to ST_DECIDE. reset clears the ring (valid bits),
// the write slot and restores register defaults. the result sits in an
// output register; a new sample is taken while it waits, and the block
// holds its next result until the old one is taken.
`default_nettype none

module range_median_outlier_filter #(
   parameter int unsigned RING_DEPTH = rmof_pkg::RING_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   rmof_req_if.sink    req_if,
   rmof_rsp_if.source  rsp_if,
   rmof_csr_if.sink    csr_if
);
   import rmof_pkg::*;

   localparam int unsigned IDX_W = $clog2(RING_DEPTH);
   localparam int unsigned SC_W  = IDX_W + 1;
   localparam int unsigned ZC_W  = $clog2(RING_DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
   localparam logic [ZC_W-1:0]  ZERO_HALF = ZC_W'(RING_DEPTH / 2);
   localparam logic signed [SC_W-1:0] SCORE_ONE = SC_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   state_type state_ff;

   range_type mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] vld_ff;
   range_type rda_ff, rdb_ff;
   logic rda_v_ff, rdb_v_ff;

   logic [IDX_W-1:0] slot_ff, i_ff, j_ff;
   range_type max_range_ff, max_dev_ff;
   range_type sample_ff;
   logic pass_ff;

   logic p_vld_ff, p_first_ff, p_last_ff, p_diag_ff, p_row0_ff;
   logic signed [SC_W-1:0] score_ff;
   logic [ZC_W-1:0] zero_ff;
   logic [IDX_W-1:0] best_ff;
   logic best_vld_ff;
   range_type med_ff;

   logic rsp_valid_ff;
   range_type rsp_data_ff;

   logic req_fire;
   range_type a_val, b_val;
   logic signed [SC_W-1:0] score_base, score_in, score_neg;
   logic [IDX_W-1:0] score_abs;
   range_type med_sel, diff;

   assign req_fire = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.filtered_range = rsp_data_ff;

   // shared comparator and score accumulate
   always_comb begin
      a_val = rda_v_ff ? rda_ff : '0;
      b_val = rdb_v_ff ? rdb_ff : '0;
      score_base = p_first_ff ? '0 : score_ff;
      if (p_diag_ff || a_val == b_val) begin
         score_in = score_base;
      end else if (a_val > b_val) begin
         score_in = score_base + SCORE_ONE;
      end else begin
         score_in = score_base - SCORE_ONE;
      end
      score_neg = -score_in;
      score_abs = score_in[SC_W-1] ? score_neg[IDX_W-1:0] : score_in[IDX_W-1:0];
      med_sel = (zero_ff >= ZERO_HALF) ? '0 : med_ff;
      diff = (sample_ff >= med_sel) ? (sample_ff - med_sel) : (med_sel - sample_ff);
   end

   // sample ring
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mem[slot_ff] <= req_if.range_sample;
      end
      rda_ff <= mem[i_ff];
      rdb_ff <= mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         slot_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         max_range_ff <= MAX_RANGE_RESET;
         max_dev_ff   <= MAX_DEV_RESET;
         sample_ff    <= '0;
         pass_ff      <= 1'b0;
         rda_v_ff     <= 1'b0;
         rdb_v_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         p_first_ff   <= 1'b0;
         p_last_ff    <= 1'b0;
         p_diag_ff    <= 1'b0;
         p_row0_ff    <= 1'b0;
         score_ff     <= '0;
         zero_ff      <= '0;
         best_ff      <= '0;
         best_vld_ff  <= 1'b0;
         med_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (csr_if.valid) begin
            case (csr_if.index)
               CSR_MAX_RANGE: max_range_ff <= csr_if.data;
               CSR_MAX_DEV:   max_dev_ff   <= csr_if.data;
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_if.ready && state_ff != ST_DECIDE) begin
            rsp_valid_ff <= 1'b0;
         end

         // compare stage tags are registered alongside the ring read data
         p_vld_ff   <= (state_ff == ST_SCAN);
         p_first_ff <= (j_ff == '0);
         p_last_ff  <= (j_ff == IDX_LAST);
         p_diag_ff  <= (i_ff == j_ff);
         p_row0_ff  <= (i_ff == '0);
         rda_v_ff   <= vld_ff[i_ff];
         rdb_v_ff   <= vld_ff[j_ff];

         if (p_vld_ff) begin
            score_ff <= score_in;
            if (p_row0_ff && b_val == '0) begin
               zero_ff <= zero_ff + ZC_W'(1);
            end
            if (p_last_ff && a_val != '0 && (!best_vld_ff || score_abs < best_ff)) begin
               best_vld_ff <= 1'b1;
               best_ff     <= score_abs;
               med_ff      <= a_val;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  sample_ff       <= req_if.range_sample;
                  pass_ff         <= (req_if.range_sample != '0) &&
                                     (req_if.range_sample < max_range_ff) &&
                                     (req_if.interval_ms < INTERVAL_LIMIT_MS);
                  vld_ff[slot_ff] <= 1'b1;
                  slot_ff         <= (slot_ff == IDX_LAST) ? '0 : slot_ff + IDX_W'(1);
                  i_ff            <= '0;
                  j_ff            <= '0;
                  zero_ff         <= '0;
                  best_vld_ff     <= 1'b0;
                  if ((req_if.range_sample != '0) &&
                      (req_if.range_sample < max_range_ff) &&
                      (req_if.interval_ms < INTERVAL_LIMIT_MS)) begin
                     state_ff <= ST_SCAN;
                  end else begin
                     state_ff <= ST_DECIDE;
                  end
               end
            end
            ST_SCAN: begin
               if (j_ff == IDX_LAST) begin
                  j_ff <= '0;
                  if (i_ff == IDX_LAST) begin
                     i_ff     <= '0;
                     state_ff <= ST_DRAIN;
                  end else begin
                     i_ff <= i_ff + IDX_W'(1);
                  end
               end else begin
                  j_ff <= j_ff + IDX_W'(1);
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= (pass_ff && diff <= max_dev_ff) ? sample_ff : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_pass_below_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.filtered_range != '0) |-> rsp_if.filtered_range < max_range_ff)
      else $error("passed sample not below range limit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("ready right after accepting a transaction");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= IDX_LAST)
      else $error("write slot out of range");

   a_zero_count_bound: assert property (@(posedge clock) disable iff (reset)
      zero_ff <= ZC_W'(RING_DEPTH))
      else $error("zero count exceeds ring depth");

   a_scan_then_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(state_ff == ST_SCAN))
      else $error("drain entered outside scan");

endmodule

`default_nettype wire

@@ tb/sv/tb_range_median_outlier_filter.sv @@
`timescale 1ns / 1ps
// tb_range_median_outlier_filter: self-checking bench for the median outlier filter.
// predicts each filtered range in a scoreboard class, drives the three channels,
// with random idling on the sample and result sides; depends on rmof_pkg, the rmof_*_if interfaces and the rtl.

module tb_range_median_outlier_filter;
   import rmof_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int DEPTH         = RING_DEPTH_DEF;
   localparam int SCORE_CEILING = 9999;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 200;
   localparam int SETTLE_CYCLES = DEPTH * DEPTH + 16;

   localparam csr_idx_type CSR_SPARE_LO = 2'd2;
   localparam csr_idx_type CSR_SPARE_HI = 2'd3;

   class outlier_scoreboard;
      range_type ring[DEPTH];
      int        slot;
      range_type max_range;
      range_type max_dev;
      range_type expected_ranges[$];
      int        errors;
      int        samples;
      int        passed;

      function new();
         foreach (ring[i]) ring[i] = '0;
         slot      = 0;
         max_range = MAX_RANGE_RESET;
         max_dev   = MAX_DEV_RESET;
         errors    = 0;
         samples   = 0;
         passed    = 0;
      endfunction

      function void set_register(csr_idx_type idx, csr_data_type value);
         case (idx)
            CSR_MAX_RANGE: max_range = value;
            CSR_MAX_DEV:   max_dev   = value;
            default: ;
         endcase
      endfunction

      // rank median: first nonzero entry with the most balanced below/above count
      function range_type ring_median();
         int        zeros;
         int        best;
         int        score;
         range_type med;
         zeros = 0;
         foreach (ring[i]) if (ring[i] == '0) zeros++;
         if (zeros >= DEPTH / 2) return '0;
         best = SCORE_CEILING;
         med  = '0;
         for (int i = 0; i < DEPTH; i++) begin
            if (ring[i] != '0) begin
               score = 0;
               for (int j = 0; j < DEPTH; j++) begin
                  if (j != i) begin
                     if (ring[i] > ring[j]) score++;
                     else if (ring[i] < ring[j]) score--;
                  end
               end
               if (score < 0) score = -score;
               if (score < best) begin
                  best = score;
                  med  = ring[i];
               end
            end
         end
         return med;
      endfunction

      function void accept_sample(range_type sample, interval_type interval);
         range_type med;
         range_type filtered;
         int        diff;
         ring[slot] = sample;
         slot       = (slot + 1) % DEPTH;
         filtered   = '0;
         if (sample != '0 && sample < max_range && interval < INTERVAL_LIMIT_MS) begin
            med  = ring_median();
            diff = (sample >= med) ? int'(sample) - int'(med) : int'(med) - int'(sample);
            if (diff <= int'(max_dev)) filtered = sample;
         end
         samples++;
         if (filtered != '0) passed++;
         expected_ranges.push_back(filtered);
      endfunction

      function void check_filtered(range_type actual);
         range_type want;
         if (expected_ranges.size() == 0) begin
            $error("filtered_range: unexpected transaction, actual %0d", actual);
            errors++;
         end else begin
            want = expected_ranges.pop_front();
            if (actual !== want) begin
               $error("filtered_range mismatch: expected %0d, actual %0d", want, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_ranges.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   rmof_req_if req_bus ();
   rmof_rsp_if rsp_bus ();
   rmof_csr_if csr_bus ();

   range_median_outlier_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   outlier_scoreboard board = new();

   bit        gaps_on;
   bit        rsp_stalls;
   bit        hold_rsp;
   int        settings_used;
   range_type base_range;
   range_type last_sample;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            board.accept_sample(req_bus.range_sample, req_bus.interval_ms);
         if (rsp_bus.valid && rsp_bus.ready)
            board.check_filtered(rsp_bus.filtered_range);
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (rsp_stalls && $urandom_range(0, 4) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #(CLOCK_PERIOD * 1_000_000);
      $display("** range_median_outlier_filter: FAILED **");
      $finish;
   end

   task automatic send_sample(range_type sample, interval_type interval);
      req_bus.valid        <= 1'b1;
      req_bus.range_sample <= sample;
      req_bus.interval_ms  <= interval;
      do @(posedge clock); while (!req_bus.ready);
      last_sample = sample;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_register(csr_idx_type idx, csr_data_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_register(idx, value);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(range_type max_range, range_type max_dev);
      write_register(CSR_MAX_RANGE, max_range);
      write_register(CSR_MAX_DEV, max_dev);
      settings_used++;
      if (max_range > 2) base_range = range_type'($urandom_range(1, max_range - 1));
      else base_range = range_type'($urandom_range(1, 65535));
   endtask

   // mostly a steady target with jitter, some outliers, zeros and pure noise
   function automatic range_type pick_sample();
      int spread;
      int value;
      spread = (board.max_dev < 8) ? 8 : int'(board.max_dev) + int'(board.max_dev) / 2;
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5: value = int'(base_range) + $urandom_range(0, 2 * spread) - spread;
         6:       value = int'(last_sample);
         7:       value = int'(base_range) + $urandom_range(0, 8 * spread) - 4 * spread;
         8:       value = 0;
         9:       value = $urandom_range(0, 65535);
         10:      value = int'(board.max_range) - $urandom_range(0, 1);
         default: value = int'(base_range);
      endcase
      if ($urandom_range(0, 15) == 0)
         base_range = range_type'($urandom_range(1,
                         (board.max_range > 2) ? board.max_range - 1 : 65535));
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
      return range_type'(value);
   endfunction

   function automatic interval_type pick_interval();
      case ($urandom_range(0, 19))
         0:       return INTERVAL_LIMIT_MS - interval_type'(1);
         1:       return INTERVAL_LIMIT_MS;
         2:       return interval_type'($urandom_range(0, 65535));
         default: return interval_type'($urandom_range(0, INTERVAL_LIMIT_MS - 1));
      endcase
   endfunction

   task automatic run_phase(int items);
      for (int n = 0; n < items; n++) begin
         if (n == items / 2 && $urandom_range(0, 1) == 0) wait_drained();
         send_sample(pick_sample(), pick_interval());
      end
      wait_drained();
   endtask

   initial begin
      range_type ranges[8];
      range_type devs[8];

      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.range_sample = '0;
      req_bus.interval_ms  = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_MAX_RANGE;
      csr_bus.data         = '0;
      gaps_on              = 1'b1;
      rsp_stalls           = 1'b1;
      hold_rsp             = 1'b0;
      settings_used        = 1;
      last_sample          = '0;
      base_range           = 16'd3000;
      ranges = '{16'd65535, 16'd0, 16'd65535, 16'd1, 16'd20000, 16'd4000, 16'd40000,
                 MAX_RANGE_RESET};
      devs   = '{16'd65535, MAX_DEV_RESET, 16'd0, 16'd0, 16'd300, 16'd50, 16'd2000,
                 MAX_DEV_RESET};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // unused register slots must leave the defaults alone
      write_register(CSR_SPARE_LO, 16'hFFFF);
      write_register(CSR_SPARE_HI, 16'h0000);

      // invalid samples and intervals, then a median forming around 3000 mm
      send_sample(16'd0, 16'd0);
      send_sample(16'd65535, 16'd0);
      send_sample(16'd9999, 16'd999);
      send_sample(16'd10000, 16'd5);
      send_sample(16'd500, 16'd1000);
      send_sample(16'd400, 16'd10);
      send_sample(16'd1, 16'd1);
      send_sample(16'd3000, 16'd20);
      send_sample(16'd3100, 16'd20);
      send_sample(16'd3050, 16'd20);
      send_sample(16'd2990, 16'd20);
      send_sample(16'd3020, 16'd65535);
      send_sample(16'd3010, 16'd30);
      send_sample(16'd6000, 16'd30);
      send_sample(16'd3400, 16'd30);
      wait_drained();
      apply_settings(16'd65535, 16'd0);
      send_sample(16'd3010, 16'd1);
      send_sample(16'd3010, 16'd1);
      wait_drained();
      apply_settings(16'd0, MAX_DEV_RESET);
      send_sample(16'd3000, 16'd1);
      send_sample(16'd1, 16'd0);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         apply_settings(ranges[p], devs[p]);
         if (p == 2) hold_rsp = 1'b1;
         if (p == 7) begin
            gaps_on    = 1'b0;
            rsp_stalls = 1'b0;
         end else begin
            gaps_on    = $urandom_range(0, 3) != 0;
            rsp_stalls = $urandom_range(0, 3) != 0;
         end
         run_phase(PHASE_ITEMS);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d samples, %0d passed the gate and %0d were rejected,",
               board.samples, board.passed, board.samples - board.passed);
      $display("across %0d register settings including zero and full-scale limits",
               settings_used);
      if (board.errors == 0) begin
         $display("** range_median_outlier_filter: PASSED **");
      end else begin
         $display("** range_median_outlier_filter: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/rmof_pkg.sv
src/rmof_req_if.sv
src/rmof_rsp_if.sv
src/rmof_csr_if.sv
src/range_median_outlier_filter.sv
tb/sv/tb_range_median_outlier_filter.sv
